/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/iue_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package iue_pkg;

    localparam int MAX_ITEM_COUNT        = 64;
    localparam int MAX_TRANSACTION_COUNT = 256;
    localparam int COST_BITS             = 16;

    localparam int ITEM_AW = (MAX_ITEM_COUNT > 1) ? $clog2(MAX_ITEM_COUNT) : 1;
    localparam int TR_AW   = (MAX_TRANSACTION_COUNT > 1) ? $clog2(MAX_TRANSACTION_COUNT) : 1;

    localparam int SET_W       = 64;
    localparam int TREE_LANES  = 64;
    localparam int S1_LANES    = TREE_LANES / 4;
    localparam int S2_LANES    = S1_LANES / 4;
    localparam int S1_W        = COST_BITS + 2;
    localparam int S2_W        = COST_BITS + 4;
    localparam int ROW_W       = COST_BITS + 6;
    localparam int UTIL_W      = 30;
    localparam int COUNT_W     = 9;
    localparam int ITEM_CNT_W  = 7;
    localparam int TR_CNT_W    = 9;
    localparam int SUM_W       = ((ROW_W > UTIL_W) ? ROW_W : UTIL_W) + 1;

    typedef logic [COST_BITS-1:0]  cost_t;
    typedef logic [ITEM_AW-1:0]    item_addr_t;
    typedef logic [TR_AW-1:0]      tr_addr_t;
    typedef logic [SET_W-1:0]      itemset_t;
    typedef logic [S1_W-1:0]       s1_sum_t;
    typedef logic [S2_W-1:0]       s2_sum_t;
    typedef logic [ROW_W-1:0]      row_sum_t;
    typedef logic [SUM_W-1:0]      wide_sum_t;
    typedef logic [UTIL_W-1:0]     util_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [ITEM_CNT_W-1:0] item_cnt_t;
    typedef logic [TR_CNT_W-1:0]   tr_cnt_t;

    localparam util_t     UTIL_MAX    = '1;
    localparam item_cnt_t ITEMS_RESET = 7'd64;
    localparam tr_cnt_t   TRANS_RESET = 9'd256;

    // Input commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ITEMS = 1'b0;
    localparam logic CFG_TRANS = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_start;
        logic     load_commit;
        logic     eval_start;
        logic     issue_vld;
        logic     issue_last;
        tr_addr_t issue_addr;
        logic     out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } dp_status_t;

    // Mask with the low n bits set; n is already clamped to the item count.
    function automatic itemset_t low_mask(item_cnt_t n);
        itemset_t m;
        m = '0;
        for (int i = 0; i < SET_W; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/iue_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module iue_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_command,
    input  wire iue_pkg::tr_cnt_t   trans_limit,
    input  wire iue_pkg::dp_status_t status,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output iue_pkg::ctrl_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    iue_pkg::tr_cnt_t row_reg, row_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept;
    logic             out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_command == iue_pkg::CMD_LOAD) begin
                        cmd.load_start = 1'b1;
                        state_next     = ST_LOAD;
                    end else begin
                        cmd.eval_start = 1'b1;
                        row_next       = '0;
                        state_next     = (trans_limit == '0) ? ST_DONE : ST_EVAL;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load_commit = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_EVAL: begin
                cmd.issue_vld  = 1'b1;
                cmd.issue_addr = iue_pkg::tr_addr_t'(row_reg);
                cmd.issue_last = (row_reg == trans_limit - iue_pkg::tr_cnt_t'(1));
                row_next       = row_reg + iue_pkg::tr_cnt_t'(1);
                if (cmd.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/iue_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module iue_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire iue_pkg::ctrl_cmd_t  cmd,
    input  wire logic [5:0]          s_item_index,
    input  wire logic [7:0]          s_transaction_index,
    input  wire logic [15:0]         s_item_cost,
    input  wire logic [63:0]         s_itemset_bits,
    input  wire iue_pkg::item_cnt_t  items_limit,
    output iue_pkg::dp_status_t      status,
    output logic [8:0]               m_support_count,
    output logic [29:0]              m_utility_sum
);

    // Load capture.
    logic                 load_ok;
    logic                 load_ok_reg;
    iue_pkg::item_addr_t  ld_item;
    iue_pkg::item_addr_t  ld_item_reg;
    iue_pkg::tr_addr_t    ld_tr;
    iue_pkg::tr_addr_t    ld_tr_reg;

    // Presence rows, one bitmap per transaction.
    iue_pkg::itemset_t    pres_mem [iue_pkg::MAX_TRANSACTION_COUNT];
    logic [iue_pkg::MAX_TRANSACTION_COUNT-1:0] row_valid_reg;
    iue_pkg::itemset_t    pres_rd_reg;
    logic                 rd_valid_reg;
    logic                 rd_en;
    iue_pkg::tr_addr_t    rd_addr;
    iue_pkg::itemset_t    pres_row;
    logic                 pres_wr;
    iue_pkg::itemset_t    pres_wr_data;

    // Evaluation pipeline.
    iue_pkg::itemset_t    mask_reg;
    iue_pkg::cost_t       cost_lane [iue_pkg::TREE_LANES];
    logic                 p0_vld_reg, p0_last_reg;
    logic                 match;
    iue_pkg::s1_sum_t     s1_sum [iue_pkg::S1_LANES];
    iue_pkg::s1_sum_t     s1_sum_reg [iue_pkg::S1_LANES];
    logic                 s1_vld_reg, s1_last_reg, s1_match_reg;
    iue_pkg::s2_sum_t     s2_sum [iue_pkg::S2_LANES];
    iue_pkg::s2_sum_t     s2_sum_reg [iue_pkg::S2_LANES];
    logic                 s2_vld_reg, s2_last_reg, s2_match_reg;
    iue_pkg::row_sum_t    s3_sum_reg;
    logic                 s3_vld_reg, s3_last_reg, s3_match_reg;
    iue_pkg::wide_sum_t   acc_wide;
    iue_pkg::util_t       util_reg;
    iue_pkg::count_t      count_reg;
    iue_pkg::count_t      m_support_count_reg;
    iue_pkg::util_t       m_utility_sum_reg;

    assign load_ok = (int'(s_item_index) < iue_pkg::MAX_ITEM_COUNT) &&
                     (int'(s_transaction_index) < iue_pkg::MAX_TRANSACTION_COUNT);
    assign ld_item = iue_pkg::item_addr_t'(s_item_index);
    assign ld_tr   = iue_pkg::tr_addr_t'(s_transaction_index);

    always_ff @(posedge aclk) begin
        if (cmd.load_start) begin
            load_ok_reg <= load_ok;
            ld_item_reg <= ld_item;
            ld_tr_reg   <= ld_tr;
        end
    end

    // One read port shared by the load read-modify-write and the row walk.
    assign rd_en   = cmd.load_start || cmd.issue_vld;
    assign rd_addr = cmd.load_start ? ld_tr : cmd.issue_addr;

    // A row that was never written reads as all zero.
    assign pres_row     = rd_valid_reg ? pres_rd_reg : '0;
    assign pres_wr      = cmd.load_commit && load_ok_reg;
    assign pres_wr_data = pres_row | (iue_pkg::itemset_t'(1) << ld_item_reg);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            pres_rd_reg  <= pres_mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
        if (pres_wr) begin
            pres_mem[ld_tr_reg] <= pres_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (pres_wr) begin
            row_valid_reg[ld_tr_reg] <= 1'b1;
        end
    end

    // Cost lanes: one memory per item, addressed by transaction.
    for (genvar lane = 0; lane < iue_pkg::TREE_LANES; lane++) begin : g_lane
        if (lane < iue_pkg::MAX_ITEM_COUNT) begin : g_mem
            iue_pkg::cost_t lane_mem [iue_pkg::MAX_TRANSACTION_COUNT];
            iue_pkg::cost_t lane_rd_reg;
            always_ff @(posedge aclk) begin
                if (cmd.load_start && load_ok && (ld_item == iue_pkg::item_addr_t'(lane))) begin
                    lane_mem[ld_tr] <= iue_pkg::cost_t'(s_item_cost);
                end
                if (cmd.issue_vld) begin
                    lane_rd_reg <= lane_mem[cmd.issue_addr];
                end
            end
            assign cost_lane[lane] = lane_rd_reg;
        end else begin : g_pad
            assign cost_lane[lane] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval_start) begin
            mask_reg <= s_itemset_bits & iue_pkg::low_mask(items_limit);
        end
    end

    // Stage 1: row match and first level of the adder tree.
    assign match = ((pres_row & mask_reg) == mask_reg);

    always_comb begin
        for (int j = 0; j < iue_pkg::S1_LANES; j++) begin
            s1_sum[j] = '0;
            for (int k = 0; k < 4; k++) begin
                if (match && mask_reg[4*j+k]) begin
                    s1_sum[j] = s1_sum[j] + iue_pkg::s1_sum_t'(cost_lane[4*j+k]);
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < iue_pkg::S2_LANES; j++) begin
            s2_sum[j] = iue_pkg::s2_sum_t'(s1_sum_reg[4*j])   +
                        iue_pkg::s2_sum_t'(s1_sum_reg[4*j+1]) +
                        iue_pkg::s2_sum_t'(s1_sum_reg[4*j+2]) +
                        iue_pkg::s2_sum_t'(s1_sum_reg[4*j+3]);
        end
    end

    always_ff @(posedge aclk) begin
        s1_sum_reg   <= s1_sum;
        s1_match_reg <= match;
        s2_sum_reg   <= s2_sum;
        s2_match_reg <= s1_match_reg;
        s3_sum_reg   <= iue_pkg::row_sum_t'(s2_sum_reg[0]) +
                        iue_pkg::row_sum_t'(s2_sum_reg[1]) +
                        iue_pkg::row_sum_t'(s2_sum_reg[2]) +
                        iue_pkg::row_sum_t'(s2_sum_reg[3]);
        s3_match_reg <= s2_match_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg  <= 1'b0;
            p0_last_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s3_last_reg <= 1'b0;
        end else begin
            p0_vld_reg  <= cmd.issue_vld;
            p0_last_reg <= cmd.issue_vld && cmd.issue_last;
            s1_vld_reg  <= p0_vld_reg;
            s1_last_reg <= p0_last_reg;
            s2_vld_reg  <= s1_vld_reg;
            s2_last_reg <= s1_last_reg;
            s3_vld_reg  <= s2_vld_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Accumulate with saturation; the running sum only grows, so clamping
    // after every row matches clamping at the end.
    assign acc_wide = iue_pkg::wide_sum_t'(util_reg) + iue_pkg::wide_sum_t'(s3_sum_reg);

    always_ff @(posedge aclk) begin
        if (cmd.eval_start) begin
            count_reg <= '0;
            util_reg  <= '0;
        end else if (s3_vld_reg) begin
            count_reg <= count_reg + iue_pkg::count_t'(s3_match_reg);
            util_reg  <= (acc_wide > iue_pkg::wide_sum_t'(iue_pkg::UTIL_MAX)) ?
                         iue_pkg::UTIL_MAX : iue_pkg::util_t'(acc_wide);
        end
    end

    assign status.done = s3_vld_reg && s3_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_support_count_reg <= count_reg;
            m_utility_sum_reg   <= util_reg;
        end
    end

    assign m_support_count = m_support_count_reg;
    assign m_utility_sum   = m_utility_sum_reg;

endmodule

`default_nettype wire

/* rtl/core/itemset_utility_evaluator_core.sv */
// Itemset utility evaluator.
// Input channel (s_valid/s_ready): each item is a command. A load item
// (s_command = 0) sets the presence bit of one item in one transaction row
// and stores its cost; it produces no result. An evaluate
// item (s_command = 1) walks the in-use transaction rows one per cycle and
// produces one result item on the output channel (m_valid/m_ready) carrying
// the number of matching rows and their saturated utility sum.
// With rows in use the result is offered once the last row has passed
// the pipeline, and the next input item can be taken from the cycle the
// result is offered, so evaluations never overlap; with no rows in use
// the row walk is skipped. The row walk reads one presence
// row and 64 cost lanes per cycle and feeds a three-stage registered adder
// tree and an accumulator.
// Configuration writes (cfg_valid/cfg_ready, always ready) set items_in_use
// (index 0) and transactions_in_use (index 1); write them only while idle.
// Reset (aresetn low, synchronous) clears the presence rows through their
// valid bits at once and restores both registers to their defaults; costs
// stay undefined until loaded. A stalled result is held in the output
// register; the block keeps taking load items meanwhile, and a following
// evaluation waits at its end until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module itemset_utility_evaluator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [5:0]  s_item_index,
    input  wire logic [7:0]  s_transaction_index,
    input  wire logic [15:0] s_item_cost,
    input  wire logic [63:0] s_itemset_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [8:0]       m_support_count,
    output logic [29:0]      m_utility_sum
);

    iue_pkg::item_cnt_t  items_in_use_reg;
    iue_pkg::tr_cnt_t    transactions_in_use_reg;
    iue_pkg::item_cnt_t  items_limit;
    iue_pkg::tr_cnt_t    trans_limit;
    iue_pkg::ctrl_cmd_t  cmd;
    iue_pkg::dp_status_t status;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            items_in_use_reg        <= iue_pkg::ITEMS_RESET;
            transactions_in_use_reg <= iue_pkg::TRANS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                iue_pkg::CFG_ITEMS: begin
                    items_in_use_reg <= cfg_data[iue_pkg::ITEM_CNT_W-1:0];
                end
                iue_pkg::CFG_TRANS: begin
                    transactions_in_use_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Registers above the table size act as the table size.
    assign items_limit = (int'(items_in_use_reg) > iue_pkg::MAX_ITEM_COUNT) ?
                         iue_pkg::item_cnt_t'(iue_pkg::MAX_ITEM_COUNT) : items_in_use_reg;
    assign trans_limit = (int'(transactions_in_use_reg) > iue_pkg::MAX_TRANSACTION_COUNT) ?
                         iue_pkg::tr_cnt_t'(iue_pkg::MAX_TRANSACTION_COUNT) :
                         transactions_in_use_reg;

    iue_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .trans_limit (trans_limit),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd)
    );

    iue_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .s_item_index        (s_item_index),
        .s_transaction_index (s_transaction_index),
        .s_item_cost         (s_item_cost),
        .s_itemset_bits      (s_itemset_bits),
        .items_limit         (items_limit),
        .status              (status),
        .m_support_count     (m_support_count),
        .m_utility_sum       (m_utility_sum)
    );

endmodule

`default_nettype wire

/* rtl/core/iue_sva.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module iue_sva (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_command,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [8:0]  m_support_count,
    input wire logic [29:0] m_utility_sum
);

    // A held result stays offered and unchanged until taken.
    `ASSERT_CLK(a_result_held, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped while stalled")
    `ASSERT_CLK(a_result_stable, aclk, aresetn, (m_valid && !m_ready) |=> ($stable(m_support_count) && $stable(m_utility_sum)), "result changed while stalled")

    // A load is a read-modify-write of its row, so the next cycle is busy.
    `ASSERT_CLK(a_load_busy, aclk, aresetn, (s_valid && s_ready && !s_command) |=> !s_ready, "input ready right after a load")

    // Out of reset the block is idle and has no result pending.
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (s_ready && !m_valid), "block not idle after reset")

    // A count never exceeds the number of transaction rows.
    `ASSERT_CLK(a_count_range, aclk, aresetn, m_valid |-> (m_support_count <= 9'd256), "support count out of range")

endmodule

bind itemset_utility_evaluator_core iue_sva u_iue_sva (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_command       (s_command),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_support_count (m_support_count),
    .m_utility_sum   (m_utility_sum)
);

`default_nettype wire
